// ----- design/mms_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Motor move supervisor package
// Shared widths, reset values, register indexes, operation kinds and result status codes.
// ---------------------------------------------------------------------------
package mms_pkg;

   // Configuration register widths.
   localparam int POWER_W   = 10;
   localparam int TIMEOUT_W = 16;
   localparam int TRAVEL_W  = 16;

   // Configuration port geometry.
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Result field widths and packed result size.
   localparam int DRIVE_W    = 11;
   localparam int STATUS_W   = 3;
   localparam int RSP_DATA_W = 16;

   // Register values after reset.
   localparam logic [POWER_W-1:0]   POWER_RESET  = 10'd500;
   localparam logic [TIMEOUT_W-1:0] ENGAGE_RESET = 16'd1000;
   localparam logic [TIMEOUT_W-1:0] STALL_RESET  = 16'd200;
   localparam logic [TRAVEL_W-1:0]  TRAVEL_RESET = 16'd2500;

   // Register indexes, taken from paddr[3:2].
   typedef enum logic [1:0] {
      REG_DRIVE_POWER = 2'd0,
      REG_ENGAGE_TO   = 2'd1,
      REG_STALL_TO    = 2'd2,
      REG_MAX_TRAVEL  = 2'd3
   } reg_index_type;

   // Input operation kinds.
   typedef enum logic {
      OP_START  = 1'b0,
      OP_SAMPLE = 1'b1
   } op_type;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      ST_IDLE          = 3'd0,
      ST_RUNNING       = 3'd1,
      ST_DONE          = 3'd2,
      ST_TOO_FAR       = 3'd3,
      ST_ENGAGE_TO     = 3'd4,
      ST_HIT_LIMIT     = 3'd5,
      ST_TRAVEL_LIMIT  = 3'd6
   } status_type;

endpackage
`default_nettype wire

// ----- design/motor_move_supervisor.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Motor move supervisor
// Supervises one encoder-driven motor move: starts drive towards a target,
// then checks each encoder sample for engage timeout, stall, overrun and
// arrival, braking the motor on every finish.
// ---------------------------------------------------------------------------
//
//  Channel | Direction | Handshake             | Contents
//  --------+-----------+-----------------------+------------------------------
//  req_    | in        | tvalid/tready         | start or sample transaction
//  rsp_    | out       | tvalid/tready         | drive, status, reversed flag
//  csr_    | in/out    | APB, pready always 1  | four configuration registers
//
//  Each transaction's result is valid in the cycle after its acceptance; one
//  may be accepted in every cycle, limited only by the result register.
//  The result register drains while a new transaction is taken, so req_tready
//  falls only while a result waits and rsp_tready is low.
//  Reset is synchronous: it clears the running and engaged flags, the result
//  valid flag and loads the register defaults.
//  Configuration writes are meant to be made while the block is idle.
// ---------------------------------------------------------------------------
module motor_move_supervisor #(
   parameter int POSITION_BITS = 16,
   parameter int TIME_BITS     = 32
) (
   input  wire                                clock,
   input  wire                                reset,
   // Request stream
   input  wire                                req_tvalid,
   output logic                               req_tready,
   // tdata, low bit first: target_position, want_forward, encoder_pos,
   // now_ms, zero padding to whole bytes
   input  wire [((2*POSITION_BITS+1+TIME_BITS+7)/8)*8-1:0] req_tdata,
   // tuser: op
   input  wire                                req_tuser,
   // Response stream
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   // tdata, low bit first: motor_drive, status, reversed, zero padding
   output logic [mms_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // Configuration port
   input  wire                                csr_psel,
   input  wire                                csr_penable,
   input  wire                                csr_pwrite,
   input  wire [mms_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  wire [mms_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [mms_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);

   localparam int P     = POSITION_BITS;
   localparam int T     = TIME_BITS;
   localparam int CMP_W = (P + 1 > mms_pkg::TRAVEL_W) ? P + 1 : mms_pkg::TRAVEL_W;

   // Configuration registers
   logic [mms_pkg::POWER_W-1:0]   drive_power_ff;
   logic [mms_pkg::TIMEOUT_W-1:0] engage_to_ff;
   logic [mms_pkg::TIMEOUT_W-1:0] stall_to_ff;
   logic [mms_pkg::TRAVEL_W-1:0]  max_travel_ff;

   // Move state
   logic                 running_ff, running_in;
   logic                 engaged_ff, engaged_in;
   logic                 drive_fwd_ff, drive_fwd_in;
   logic                 was_rev_ff, was_rev_in;
   logic signed [P-1:0]  start_pos_ff, start_pos_in;
   logic [P:0]           needed_ff, needed_in;
   logic signed [P-1:0]  prev_pos_ff, prev_pos_in;
   logic [T-1:0]         start_time_ff, start_time_in;
   logic [T-1:0]         last_chg_ff, last_chg_in;

   // Result register
   logic                             rsp_valid_ff;
   logic signed [mms_pkg::DRIVE_W-1:0] rsp_drive_ff, rsp_drive_in;
   mms_pkg::status_type              rsp_status_ff, rsp_status_in;
   logic                             rsp_rev_ff, rsp_rev_in;

   // Unpacked request fields
   logic signed [P-1:0] f_target;
   logic                f_want_fwd;
   logic signed [P-1:0] f_pos;
   logic [T-1:0]        f_now;
   mms_pkg::op_type     f_op;

   logic req_accept;
   logic csr_write;

   // Intermediate values
   logic signed [P:0]   start_diff;
   logic [P:0]          start_steps;
   logic signed [P:0]   trav_diff;
   logic [P:0]          travelled;
   logic                start_rev;
   logic                start_fwd;
   logic [T-1:0]        since_start;
   logic [T-1:0]        since_change;
   logic                too_far;
   logic                over_travel;
   logic                arrived;
   logic signed [mms_pkg::DRIVE_W-1:0] power_ext;

   assign f_target   = req_tdata[P-1:0];
   assign f_want_fwd = req_tdata[P];
   assign f_pos      = req_tdata[2*P:P+1];
   assign f_now      = req_tdata[2*P+T:2*P+1];
   assign f_op       = mms_pkg::op_type'(req_tuser);

   // Handshakes
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Configuration register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         drive_power_ff <= mms_pkg::POWER_RESET;
         engage_to_ff   <= mms_pkg::ENGAGE_RESET;
         stall_to_ff    <= mms_pkg::STALL_RESET;
         max_travel_ff  <= mms_pkg::TRAVEL_RESET;
      end else if (csr_write) begin
         case (mms_pkg::reg_index_type'(csr_paddr[3:2]))
            mms_pkg::REG_DRIVE_POWER: drive_power_ff <= csr_pwdata[mms_pkg::POWER_W-1:0];
            mms_pkg::REG_ENGAGE_TO:   engage_to_ff   <= csr_pwdata[mms_pkg::TIMEOUT_W-1:0];
            mms_pkg::REG_STALL_TO:    stall_to_ff    <= csr_pwdata[mms_pkg::TIMEOUT_W-1:0];
            mms_pkg::REG_MAX_TRAVEL:  max_travel_ff  <= csr_pwdata[mms_pkg::TRAVEL_W-1:0];
            default: ;
         endcase
      end
   end

   // Register read-back.
   always_comb begin
      case (mms_pkg::reg_index_type'(csr_paddr[3:2]))
         mms_pkg::REG_DRIVE_POWER:
            csr_prdata = {{(mms_pkg::CSR_DATA_W-mms_pkg::POWER_W){1'b0}}, drive_power_ff};
         mms_pkg::REG_ENGAGE_TO:
            csr_prdata = {{(mms_pkg::CSR_DATA_W-mms_pkg::TIMEOUT_W){1'b0}}, engage_to_ff};
         mms_pkg::REG_STALL_TO:
            csr_prdata = {{(mms_pkg::CSR_DATA_W-mms_pkg::TIMEOUT_W){1'b0}}, stall_to_ff};
         mms_pkg::REG_MAX_TRAVEL:
            csr_prdata = {{(mms_pkg::CSR_DATA_W-mms_pkg::TRAVEL_W){1'b0}}, max_travel_ff};
         default:
            csr_prdata = '0;
      endcase
   end

   // Distances and elapsed times.
   assign start_diff   = {f_target[P-1], f_target} - {f_pos[P-1], f_pos};
   assign start_steps  = start_diff[P] ? (~start_diff + 1'b1) : start_diff;
   assign trav_diff    = {f_pos[P-1], f_pos} - {start_pos_ff[P-1], start_pos_ff};
   assign travelled    = trav_diff[P] ? (~trav_diff + 1'b1) : trav_diff;
   assign start_rev    = f_want_fwd ? (f_target < f_pos) : (f_target > f_pos);
   assign start_fwd    = f_want_fwd ^ start_rev;
   assign since_start  = f_now - start_time_ff;
   assign since_change = f_now - last_chg_ff;
   assign too_far      = CMP_W'(start_steps) > CMP_W'(max_travel_ff);
   assign over_travel  = CMP_W'(travelled) > CMP_W'(max_travel_ff);
   assign arrived      = travelled >= needed_ff;
   assign power_ext    = {1'b0, drive_power_ff};

   // Move supervision: next state and result for the offered transaction.
   always_comb begin
      running_in    = running_ff;
      engaged_in    = engaged_ff;
      drive_fwd_in  = drive_fwd_ff;
      was_rev_in    = was_rev_ff;
      start_pos_in  = start_pos_ff;
      needed_in     = needed_ff;
      prev_pos_in   = prev_pos_ff;
      start_time_in = start_time_ff;
      last_chg_in   = last_chg_ff;
      rsp_drive_in  = '0;
      rsp_status_in = mms_pkg::ST_IDLE;
      rsp_rev_in    = 1'b0;

      if (f_op == mms_pkg::OP_START) begin
         // A start abandons any running move and sets up the new one.
         drive_fwd_in  = start_fwd;
         was_rev_in    = start_rev;
         start_pos_in  = f_pos;
         prev_pos_in   = f_pos;
         needed_in     = start_steps;
         engaged_in    = 1'b0;
         start_time_in = f_now;
         last_chg_in   = f_now;
         rsp_rev_in    = start_rev;
         if (too_far) begin
            running_in    = 1'b0;
            rsp_status_in = mms_pkg::ST_TOO_FAR;
         end else begin
            running_in    = 1'b1;
            rsp_status_in = mms_pkg::ST_RUNNING;
            rsp_drive_in  = start_fwd ? power_ext : -power_ext;
         end
      end else if (running_ff) begin
         rsp_rev_in = was_rev_ff;
         if (!engaged_ff && (since_start > T'(engage_to_ff))) begin
            running_in    = 1'b0;
            engaged_in    = 1'b0;
            rsp_status_in = mms_pkg::ST_ENGAGE_TO;
         end else if (engaged_ff && (f_pos == prev_pos_ff)
                      && (since_change > T'(stall_to_ff))) begin
            running_in    = 1'b0;
            engaged_in    = 1'b0;
            rsp_status_in = mms_pkg::ST_HIT_LIMIT;
         end else begin
            // Motion tracking, then the distance checks.
            if (!engaged_ff) begin
               if (f_pos != start_pos_ff) begin
                  engaged_in  = 1'b1;
                  last_chg_in = f_now;
               end
            end else if (f_pos != prev_pos_ff) begin
               last_chg_in = f_now;
            end
            prev_pos_in = f_pos;
            if (over_travel) begin
               running_in    = 1'b0;
               engaged_in    = 1'b0;
               rsp_status_in = mms_pkg::ST_TRAVEL_LIMIT;
            end else if (arrived) begin
               running_in    = 1'b0;
               engaged_in    = 1'b0;
               rsp_status_in = mms_pkg::ST_DONE;
            end else begin
               rsp_status_in = mms_pkg::ST_RUNNING;
               rsp_drive_in  = drive_fwd_ff ? power_ext : -power_ext;
            end
         end
      end
   end

   // Move state and control flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff   <= 1'b0;
         engaged_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            running_ff <= running_in;
            engaged_ff <= engaged_in;
         end
         if (req_accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Move payload state and the result register.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         drive_fwd_ff  <= drive_fwd_in;
         was_rev_ff    <= was_rev_in;
         start_pos_ff  <= start_pos_in;
         needed_ff     <= needed_in;
         prev_pos_ff   <= prev_pos_in;
         start_time_ff <= start_time_in;
         last_chg_ff   <= last_chg_in;
         rsp_drive_ff  <= rsp_drive_in;
         rsp_status_ff <= rsp_status_in;
         rsp_rev_ff    <= rsp_rev_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(mms_pkg::RSP_DATA_W-mms_pkg::DRIVE_W-mms_pkg::STATUS_W-1){1'b0}},
                        rsp_rev_ff, rsp_status_ff, rsp_drive_ff};

   // Only a running move drives the motor.
   a_brake_unless_running: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff != mms_pkg::ST_RUNNING) |-> rsp_drive_ff == '0)
      else $error("motor driven on a result that is not running");

   // A move cannot be engaged without running.
   a_engaged_implies_running: assert property (@(posedge clock) disable iff (reset)
      !running_ff |-> !engaged_ff)
      else $error("engaged flag set while no move runs");

   // Every accepted transaction leaves a result waiting.
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted transaction produced no result");

   // A running result agrees with the move state.
   a_running_status: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (rsp_status_ff == mms_pkg::ST_RUNNING) == running_ff)
      else $error("result status disagrees with move state");

endmodule
`default_nettype wire

// ----- verif/motor_move_supervisor_test.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Motor move supervisor testbench
// Runs a directed table of moves followed by randomised move sequences
// across several register settings. A predictor of the move state machine
// tracks every accepted transaction, and each result is checked field by
// field in order, with random gaps on the request stream and back-pressure on the response stream.
// ---------------------------------------------------------------------------
module motor_move_supervisor_test;

   localparam int REQ_W       = ((2*16 + 1 + 32 + 7) / 8) * 8;
   localparam int PHASE_ITEMS = 240;
   localparam int CYCLE_LIMIT = 400000;

   // Expected result of one transaction.
   typedef struct packed {
      logic signed [mms_pkg::DRIVE_W-1:0] drive;
      mms_pkg::status_type                status;
      logic                               rev;
   } outcome_type;

   // One row of the directed table.
   typedef struct packed {
      mms_pkg::op_type    op;
      logic signed [15:0] tgt;
      logic               fwd;
      logic signed [15:0] pos;
      logic [31:0]        now;
      logic               typed;
      outcome_type        expd;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;
   logic             req_tuser  = 1'b0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [mms_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic             csr_psel    = 1'b0;
   logic             csr_penable = 1'b0;
   logic             csr_pwrite  = 1'b0;
   logic [mms_pkg::CSR_ADDR_W-1:0] csr_paddr  = '0;
   logic [mms_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [mms_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic             csr_pready;

   // Predicted register contents.
   logic [mms_pkg::POWER_W-1:0]   cfg_power  = mms_pkg::POWER_RESET;
   logic [mms_pkg::TIMEOUT_W-1:0] cfg_engage = mms_pkg::ENGAGE_RESET;
   logic [mms_pkg::TIMEOUT_W-1:0] cfg_stall  = mms_pkg::STALL_RESET;
   logic [mms_pkg::TRAVEL_W-1:0]  cfg_travel = mms_pkg::TRAVEL_RESET;

   // Predicted move state.
   bit                 mv_running  = 1'b0;
   bit                 mv_engaged  = 1'b0;
   bit                 mv_forward  = 1'b0;
   bit                 mv_reversed = 1'b0;
   logic signed [15:0] origin_pos  = '0;
   logic signed [15:0] last_pos    = '0;
   logic [16:0]        span        = '0;
   logic [31:0]        t_start     = '0;
   logic [31:0]        t_change    = '0;

   outcome_type pending_outcomes[$];
   int          failures  = 0;
   int          cycles    = 0;
   int          gap_pct   = 0;
   int          stall_pct = 0;
   row_type     steps[$];

   motor_move_supervisor dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always #4 clock = ~clock;

   // The run is abandoned if it goes on far longer than any correct run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("motor_move_supervisor_test NOT OK");
         $finish;
      end
   end

   function automatic outcome_type result_of(int drv, mms_pkg::status_type st, bit rv);
      outcome_type o;
      o.drive  = drv[mms_pkg::DRIVE_W-1:0];
      o.status = st;
      o.rev    = rv;
      return o;
   endfunction

   function automatic int fit16(int v);
      return (v > 32767) ? 32767 : (v < -32768) ? -32768 : v;
   endfunction

   function automatic row_type stim(mms_pkg::op_type op, int tgt, bit fwd, int pos,
                                    logic [31:0] now, bit typed, int drv,
                                    mms_pkg::status_type st, bit rv);
      row_type r;
      r.op    = op;
      r.tgt   = tgt[15:0];
      r.fwd   = fwd;
      r.pos   = pos[15:0];
      r.now   = now;
      r.typed = typed;
      r.expd  = result_of(drv, st, rv);
      return r;
   endfunction

   function automatic int drive_now();
      return mv_forward ? int'(cfg_power) : -int'(cfg_power);
   endfunction

   // Every finish brakes the motor and keeps the reversed flag of the move.
   function automatic outcome_type brake(mms_pkg::status_type st);
      mv_running = 1'b0;
      mv_engaged = 1'b0;
      return result_of(0, st, mv_reversed);
   endfunction

   // Advances the move state by one transaction and returns its result.
   function automatic outcome_type predict_move(mms_pkg::op_type op, logic signed [15:0] tgt,
                                                logic fwd, logic signed [15:0] pos,
                                                logic [31:0] now);
      int          reach;
      int          moved;
      bit          flip;
      logic [31:0] elapsed;
      if (op == mms_pkg::OP_START) begin
         flip = (fwd && tgt < pos) || (!fwd && tgt > pos);
         mv_forward  = fwd ^ flip;
         mv_reversed = flip;
         origin_pos  = pos;
         last_pos    = pos;
         reach = int'(tgt) - int'(pos);
         if (reach < 0) reach = -reach;
         span       = reach[16:0];
         mv_engaged = 1'b0;
         t_start    = now;
         t_change   = now;
         if (reach > int'(cfg_travel)) begin
            mv_running = 1'b0;
            return result_of(0, mms_pkg::ST_TOO_FAR, flip);
         end
         mv_running = 1'b1;
         return result_of(drive_now(), mms_pkg::ST_RUNNING, flip);
      end
      if (!mv_running) return result_of(0, mms_pkg::ST_IDLE, 1'b0);
      // Waiting for first motion, or watching for a stall once moving.
      if (!mv_engaged) begin
         elapsed = now - t_start;
         if (elapsed > {16'd0, cfg_engage}) return brake(mms_pkg::ST_ENGAGE_TO);
         if (pos != origin_pos) begin
            mv_engaged = 1'b1;
            t_change   = now;
         end
      end else begin
         elapsed = now - t_change;
         if (pos != last_pos) t_change = now;
         else if (elapsed > {16'd0, cfg_stall}) return brake(mms_pkg::ST_HIT_LIMIT);
      end
      last_pos = pos;
      moved = int'(pos) - int'(origin_pos);
      if (moved < 0) moved = -moved;
      if (moved > int'(cfg_travel)) return brake(mms_pkg::ST_TRAVEL_LIMIT);
      if (moved >= int'(span)) return brake(mms_pkg::ST_DONE);
      return result_of(drive_now(), mms_pkg::ST_RUNNING, mv_reversed);
   endfunction

   task automatic log_fail(string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
   endtask

   // Offers one transaction, waits for its acceptance and records its result.
   task automatic send_item(mms_pkg::op_type op, logic signed [15:0] tgt, logic fwd,
                            logic signed [15:0] pos, logic [31:0] now,
                            bit typed, outcome_type typed_exp);
      outcome_type predicted;
      while ($urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {7'd0, now, pos, fwd, tgt};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = predict_move(op, tgt, fwd, pos, now);
      pending_outcomes.push_back(typed ? typed_exp : predicted);
   endtask

   // Stops sending and waits until every expected result has arrived.
   task automatic settle(int tail);
      req_tvalid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   task automatic write_reg(mms_pkg::reg_index_type idx, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         mms_pkg::REG_DRIVE_POWER: cfg_power  = value[mms_pkg::POWER_W-1:0];
         mms_pkg::REG_ENGAGE_TO:   cfg_engage = value[mms_pkg::TIMEOUT_W-1:0];
         mms_pkg::REG_STALL_TO:    cfg_stall  = value[mms_pkg::TIMEOUT_W-1:0];
         default:                  cfg_travel = value[mms_pkg::TRAVEL_W-1:0];
      endcase
      @(posedge clock);
   endtask

   task automatic set_config(int power, int engage, int stall, int travel);
      write_reg(mms_pkg::REG_DRIVE_POWER, power);
      write_reg(mms_pkg::REG_ENGAGE_TO, engage);
      write_reg(mms_pkg::REG_STALL_TO, stall);
      write_reg(mms_pkg::REG_MAX_TRAVEL, travel);
   endtask

   // Mostly well-formed moves: a start, then samples that creep towards the
   // target with occasional stalls, overshoots and jumps; some pure noise.
   task automatic make_moves(int budget);
      int                 sent;
      int                 nsamp;
      int                 i;
      int                 r;
      int                 p;
      int                 left;
      int                 mag;
      int                 dir;
      int                 step;
      bit                 keep;
      logic signed [15:0] home_pos;
      logic signed [15:0] tgt;
      logic [31:0]        now;
      sent = 0;
      while (sent < budget) begin
         r = $urandom_range(99);
         if (r < 8) begin
            send_item(mms_pkg::op_type'($urandom_range(1)), 16'($urandom),
                      1'($urandom_range(1)), 16'($urandom), $urandom, 1'b0, '0);
            sent++;
         end else begin
            home_pos = 16'($urandom);
            r = $urandom_range(99);
            if (r < 6) begin
               tgt = 16'($urandom);
            end else if (r < 14) begin
               tgt = home_pos;
            end else begin
               if (r < 24) step = int'(cfg_travel) + $urandom_range(1);
               else step = $urandom_range(0, (cfg_travel < 3000) ? int'(cfg_travel) + 2 : 3000);
               tgt = 16'(fit16(int'(home_pos) + ($urandom_range(1) ? step : -step)));
            end
            if ($urandom_range(9) == 0) now = 32'hFFFF_FFFF - $urandom_range(500);
            else now = $urandom;
            send_item(mms_pkg::OP_START, tgt, 1'($urandom_range(1)), home_pos, now, 1'b0, '0);
            sent++;
            p     = home_pos;
            nsamp = $urandom_range(1, 10);
            i     = 0;
            keep  = 1'b1;
            while (keep && i < nsamp && sent < budget) begin
               left = int'(tgt) - p;
               mag  = (left < 0) ? -left : left;
               dir  = (left > 0) ? 1 : (left < 0) ? -1 : ($urandom_range(1) ? 1 : -1);
               r = $urandom_range(99);
               if (r >= 15 && r < 80) p = fit16(p + dir * int'($urandom_range(1, mag / 2 + 1)));
               else if (r >= 80 && r < 90) p = fit16(int'(tgt) + dir * int'($urandom_range(20)));
               else if (r >= 90) p = int'($urandom_range(65535)) - 32768;
               r = $urandom_range(99);
               if (r < 65) now = now + $urandom_range(0, cfg_stall / 2 + 1);
               else if (r < 80) now = now + cfg_stall + $urandom_range(1);
               else if (r < 90) now = now + cfg_engage + $urandom_range(1);
               else now = now + $urandom;
               send_item(mms_pkg::OP_SAMPLE, 16'($urandom), 1'($urandom_range(1)), 16'(p), now,
                         1'b0, '0);
               sent++;
               i++;
               if (!mv_running && $urandom_range(3) != 0) keep = 1'b0;
            end
         end
      end
   endtask

   // Result checking against the oldest expectation.
   always @(posedge clock) begin : rsp_check
      outcome_type got;
      outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.drive  = rsp_tdata[mms_pkg::DRIVE_W-1:0];
         got.status = mms_pkg::status_type'(rsp_tdata[mms_pkg::DRIVE_W +: mms_pkg::STATUS_W]);
         got.rev    = rsp_tdata[mms_pkg::DRIVE_W + mms_pkg::STATUS_W];
         if (pending_outcomes.size() == 0) begin
            log_fail($sformatf("unexpected result: drive %0d status %0d rev %0b",
                               got.drive, got.status, got.rev));
         end else begin
            want = pending_outcomes.pop_front();
            if (got.drive !== want.drive || got.status !== want.status
                || got.rev !== want.rev)
               log_fail($sformatf({"result mismatch: expected drive %0d status %0d rev %0b,",
                                   " got drive %0d status %0d rev %0b"},
                                  want.drive, want.status, want.rev,
                                  got.drive, got.status, got.rev));
         end
      end
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   initial begin
      // Directed table, run on the register values after reset.
      steps.push_back(stim(mms_pkg::OP_SAMPLE, 0, 0, 123, 5, 1, 0, mms_pkg::ST_IDLE, 0));
      steps.push_back(stim(mms_pkg::OP_START, 100, 1, 0, 0, 1, 500, mms_pkg::ST_RUNNING, 0));
      steps.push_back(stim(mms_pkg::OP_SAMPLE, 0, 0, 0, 10, 0, 0, mms_pkg::ST_IDLE, 0));
      steps.push_back(stim(mms_pkg::OP_SAMPLE, 0, 0, 50, 20, 0, 0, mms_pkg::ST_IDLE, 0));
      steps.push_back(stim(mms_pkg::OP_SAMPLE, 0, 0, 100, 30, 1, 0, mms_pkg::ST_DONE, 0));
      // Target behind the wanted direction, then no motion in time.
      steps.push_back(stim(mms_pkg::OP_START, -100, 1, 0, 100, 1, -500,
                           mms_pkg::ST_RUNNING, 1));
      steps.push_back(stim(mms_pkg::OP_SAMPLE, 0, 0, 0, 1101, 1, 0,
                           mms_pkg::ST_ENGAGE_TO, 1));
      // Distances refused outright, the widest one reversed too.
      steps.push_back(stim(mms_pkg::OP_START, 3000, 1, 0, 200, 1, 0, mms_pkg::ST_TOO_FAR, 0));
      steps.push_back(stim(mms_pkg::OP_START, 32767, 0, -32768, 32'hFFFF_FFF0, 1, 0,
                           mms_pkg::ST_TOO_FAR, 1));
      // Distance exactly at the limit, time wrapping, then a stall.
      steps.push_back(stim(mms_pkg::OP_START, 2500, 1, 0, 32'hFFFF_FF00, 1, 500,
                           mms_pkg::ST_RUNNING, 0));
      steps.push_back(stim(mms_pkg::OP_SAMPLE, -1, 1, 1, 32'h0000_0010, 0, 0,
                           mms_pkg::ST_IDLE, 0));
      steps.push_back(stim(mms_pkg::OP_SAMPLE, 0, 0, 1, 32'h0000_00D8, 0, 0,
                           mms_pkg::ST_IDLE, 0));
      steps.push_back(stim(mms_pkg::OP_SAMPLE, 0, 0, 1, 32'h0000_00D9, 1, 0,
                           mms_pkg::ST_HIT_LIMIT, 0));
      // Overrun past the travel limit.
      steps.push_back(stim(mms_pkg::OP_START, 10, 1, 0, 0, 1, 500, mms_pkg::ST_RUNNING, 0));
      steps.push_back(stim(mms_pkg::OP_SAMPLE, 0, 0, 2501, 1, 1, 0,
                           mms_pkg::ST_TRAVEL_LIMIT, 0));
      // Zero distance finishes on the next sample.
      steps.push_back(stim(mms_pkg::OP_START, 7, 0, 7, 50, 1, -500, mms_pkg::ST_RUNNING, 0));
      steps.push_back(stim(mms_pkg::OP_SAMPLE, 0, 0, 7, 60, 1, 0, mms_pkg::ST_DONE, 0));
      // A start while running replaces the move; engage limit on both sides.
      steps.push_back(stim(mms_pkg::OP_START, -29000, 1, -30000, 0, 1, 500,
                           mms_pkg::ST_RUNNING, 0));
      steps.push_back(stim(mms_pkg::OP_START, -32768, 0, -31000, 5, 1, -500,
                           mms_pkg::ST_RUNNING, 0));
      steps.push_back(stim(mms_pkg::OP_SAMPLE, 0, 0, -31000, 1005, 0, 0,
                           mms_pkg::ST_IDLE, 0));
      steps.push_back(stim(mms_pkg::OP_SAMPLE, 0, 0, -32768, 1006, 1, 0,
                           mms_pkg::ST_ENGAGE_TO, 0));
      // Zero distance with the engage time already gone.
      steps.push_back(stim(mms_pkg::OP_START, 0, 1, 0, 0, 1, 500, mms_pkg::ST_RUNNING, 0));
      steps.push_back(stim(mms_pkg::OP_SAMPLE, 0, 0, 0, 2000, 1, 0,
                           mms_pkg::ST_ENGAGE_TO, 0));
      steps.push_back(stim(mms_pkg::OP_SAMPLE, 32767, 1, 32767, 32'hFFFF_FFFF, 1, 0,
                           mms_pkg::ST_IDLE, 0));

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      gap_pct   = 30;
      stall_pct = 30;
      foreach (steps[k])
         send_item(steps[k].op, steps[k].tgt, steps[k].fwd, steps[k].pos, steps[k].now,
                   steps[k].typed, steps[k].expd);
      settle(3);

      // Random phases, each with its own register setting and idling mix.
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 53; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 53; end
            default: begin gap_pct = 30; stall_pct = 30; end
         endcase
         case (ph)
            0: set_config(1023, 0, 0, 0);
            1: set_config(0, 65535, 65535, 65535);
            2: set_config(1000, 300, 40, 3000);
            3: set_config(1, 20, 5, 100);
            5: set_config(777, 1000, 200, 2500);
            6: set_config(512, 65535, 0, 65535);
            default: set_config($urandom_range(1023), $urandom_range(2000),
                                $urandom_range(400), $urandom_range(4000));
         endcase
         if (ph == 1) begin
            // The sender holds off midway until the block has drained.
            make_moves(PHASE_ITEMS / 2);
            settle(2);
            make_moves(PHASE_ITEMS - PHASE_ITEMS / 2);
         end else begin
            make_moves(PHASE_ITEMS);
         end
         settle(3);
      end

      settle(10);
      if (failures == 0)
         $display("motor_move_supervisor_test OK");
      else
         $display("motor_move_supervisor_test NOT OK");
      $finish;
   end

endmodule

// ----- files.f -----
design/mms_pkg.sv
design/motor_move_supervisor.sv
verif/motor_move_supervisor_test.sv
